// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the hash table block
// Shared concurrent assertion forms, clocked on clk and muted during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define OAHT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define OAHT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ===== hw/rtl/oaht_pkg.sv =====
// ----------------------------------------------------------------------------
// Hash table package
// Sizes, codes, slot layout and the controller/datapath link types.
// ----------------------------------------------------------------------------
package oaht_pkg;

	localparam int unsigned SLOTS     = 256;
	localparam int unsigned IdxW      = $clog2(SLOTS);
	localparam int unsigned CntW      = $clog2(SLOTS + 1);
	localparam int unsigned LoadLimit = (3 * SLOTS) / 4;
	localparam bit          SlotsPow2 = ((SLOTS & (SLOTS - 1)) == 0);
	localparam int unsigned KeyW      = 32;
	localparam int unsigned HashW     = 32;
	localparam int unsigned ValW      = 64;
	localparam int unsigned ModCntW   = $clog2(HashW);

	// Request codes; the fourth code is unused and answers as a miss.
	typedef enum logic [1:0] {
		REQ_SET = 2'd0,
		REQ_GET = 2'd1,
		REQ_DEL = 2'd2
	} req_code_t;

	typedef enum logic [1:0] {
		RSP_HIT       = 2'd0,
		RSP_INSERTED  = 2'd1,
		RSP_NOT_FOUND = 2'd2,
		RSP_FULL      = 2'd3
	} rsp_code_t;

	typedef enum logic [1:0] {
		SLOT_EMPTY = 2'd0,
		SLOT_USED  = 2'd1,
		SLOT_TOMB  = 2'd2
	} slot_state_t;

	typedef logic [IdxW-1:0] slot_idx_t;

	typedef struct packed {
		slot_state_t         state;
		logic [KeyW-1:0]     key;
		logic [ValW-1:0]     value;
	} slot_entry_t;

	typedef enum logic [2:0] {
		CTL_CLEAR,
		CTL_IDLE,
		CTL_MOD,
		CTL_LOOKUP,
		CTL_CHECK,
		CTL_FINISH
	} ctl_state_t;

	typedef struct packed {
		logic clear_step;
		logic load;
		logic mod_step;
		logic lookup;
		logic check;
		logic commit;
	} oaht_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic mod_done;
		logic probe_stop;
		logic out_free;
	} oaht_sts_t;

endpackage

// ===== hw/rtl/oaht_ifs.sv =====
// ----------------------------------------------------------------------------
// Hash table channel interfaces
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
interface oaht_req_if import oaht_pkg::*;;
	logic             valid;
	logic             ready;
	logic [1:0]       req_type;
	logic [KeyW-1:0]  key_id;
	logic [HashW-1:0] key_hash;
	logic [ValW-1:0]  write_value;

	modport source (output valid, output req_type, output key_id, output key_hash,
		output write_value, input ready);
	modport sink (input valid, input req_type, input key_id, input key_hash,
		input write_value, output ready);
endinterface

interface oaht_rsp_if import oaht_pkg::*;;
	logic            valid;
	logic            ready;
	logic [1:0]      status;
	logic [ValW-1:0] read_value;

	modport source (output valid, output status, output read_value, input ready);
	modport sink (input valid, input status, input read_value, output ready);
endinterface

// ===== hw/rtl/oaht_ctrl.sv =====
// ----------------------------------------------------------------------------
// Hash table controller
// Sequences the clearing pass, slot reduction, probe walk and commit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module oaht_ctrl import oaht_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  oaht_sts_t sts,
	output oaht_cmd_t cmd
);

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			CTL_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) begin
					state_d = CTL_IDLE;
				end
			end
			CTL_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = SlotsPow2 ? CTL_LOOKUP : CTL_MOD;
				end
			end
			CTL_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_done) begin
					state_d = CTL_LOOKUP;
				end
			end
			CTL_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = CTL_CHECK;
			end
			CTL_CHECK: begin
				cmd.check = 1'b1;
				if (sts.probe_stop) begin
					state_d = CTL_FINISH;
				end
			end
			CTL_FINISH: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = CTL_IDLE;
				end
			end
			default: begin
				state_d = CTL_IDLE;
			end
		endcase
	end

	`OAHT_ASSERT(a_clear_once, state_q != CTL_CLEAR |=> state_q != CTL_CLEAR, "clearing pass re-entered")
	`OAHT_ASSERT(a_check_after_lookup, state_q == CTL_CHECK |-> $past(state_q == CTL_LOOKUP) || $past(state_q == CTL_CHECK), "slot checked without a read issued")

endmodule

// ===== hw/rtl/oaht_dp.sv =====
// ----------------------------------------------------------------------------
// Hash table datapath
// Slot store, start slot reduction, probe registers and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module oaht_dp import oaht_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  oaht_cmd_t        cmd,
	output oaht_sts_t        sts,
	input  logic [1:0]       req_type,
	input  logic [KeyW-1:0]  key_id,
	input  logic [HashW-1:0] key_hash,
	input  logic [ValW-1:0]  write_value,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output logic [1:0]       status,
	output logic [ValW-1:0]  read_value
);

	// Slot store and its registered read port.
	slot_entry_t mem [SLOTS];
	slot_entry_t rd_q;
	slot_idx_t   rd_addr;

	// Request held for the duration of its probe.
	logic [1:0]       req_type_q;
	logic [KeyW-1:0]  key_q;
	logic [HashW-1:0] hash_q;
	logic [ValW-1:0]  wval_q;

	// Start slot reduction for slot counts that are not a power of two.
	logic [IdxW:0]        rem_q;
	logic [IdxW:0]        rem_shift;
	logic [IdxW:0]        rem_next;
	logic [ModCntW-1:0]   mod_cnt_q;

	// Probe walk.
	slot_idx_t idx_q;
	slot_idx_t idx_next;
	slot_idx_t cnt_q;
	logic      tomb_seen_q;
	slot_idx_t tomb_idx_q;
	slot_idx_t clr_idx_q;
	logic [CntW-1:0] used_q;

	// Decision of the finished probe, applied on commit.
	rsp_code_t       res_status_q;
	logic [ValW-1:0] res_value_q;
	logic            wr_en_q;
	slot_idx_t       wr_addr_q;
	logic            wr_tomb_q;
	logic            inc_q;

	logic            out_valid_q;
	logic [1:0]      out_status_q;
	logic [ValW-1:0] out_value_q;

	logic cur_empty;
	logic cur_tomb;
	logic cur_hit;
	logic last_visit;
	logic tomb_any;
	slot_idx_t tomb_where;

	rsp_code_t       dec_status;
	logic [ValW-1:0] dec_value;
	logic            dec_wr;
	slot_idx_t       dec_addr;
	logic            dec_tomb;
	logic            dec_inc;

	assign idx_next  = (idx_q == IdxW'(SLOTS - 1)) ? '0 : idx_q + 1'b1;
	assign rd_addr   = cmd.lookup ? idx_q : idx_next;

	assign rem_shift = {rem_q[IdxW-1:0], hash_q[mod_cnt_q]};
	assign rem_next  = (rem_shift >= (IdxW+1)'(SLOTS)) ?
		rem_shift - (IdxW+1)'(SLOTS) : rem_shift;

	assign cur_empty  = (rd_q.state == SLOT_EMPTY);
	assign cur_tomb   = (rd_q.state == SLOT_TOMB);
	assign cur_hit    = (rd_q.state == SLOT_USED) && (rd_q.key == key_q);
	assign last_visit = (cnt_q == IdxW'(SLOTS - 1));
	assign tomb_any   = tomb_seen_q || cur_tomb;
	assign tomb_where = tomb_seen_q ? tomb_idx_q : idx_q;

	assign sts.clear_last = (clr_idx_q == IdxW'(SLOTS - 1));
	assign sts.mod_done   = (mod_cnt_q == '0);
	assign sts.probe_stop = cur_empty || cur_hit || last_visit;
	assign sts.out_free   = !out_valid_q || rsp_ready;

	assign rsp_valid  = out_valid_q;
	assign status     = out_status_q;
	assign read_value = out_value_q;

	always_comb begin
		dec_status = RSP_NOT_FOUND;
		dec_value  = '0;
		dec_wr     = 1'b0;
		dec_addr   = idx_q;
		dec_tomb   = 1'b0;
		dec_inc    = 1'b0;
		case (req_code_t'(req_type_q))
			REQ_SET: begin
				if (cur_hit) begin
					dec_status = RSP_HIT;
					dec_wr     = 1'b1;
				end else if (cur_empty && !tomb_any) begin
					if (used_q >= CntW'(LoadLimit)) begin
						dec_status = RSP_FULL;
					end else begin
						dec_status = RSP_INSERTED;
						dec_wr     = 1'b1;
						dec_inc    = 1'b1;
					end
				end else if (tomb_any) begin
					dec_status = RSP_INSERTED;
					dec_wr     = 1'b1;
					dec_addr   = tomb_where;
				end else begin
					dec_status = RSP_FULL;
				end
			end
			REQ_GET: begin
				if (cur_hit) begin
					dec_status = RSP_HIT;
					dec_value  = rd_q.value;
				end
			end
			REQ_DEL: begin
				if (cur_hit) begin
					dec_status = RSP_HIT;
					dec_wr     = 1'b1;
					dec_tomb   = 1'b1;
				end
			end
			default: begin
				dec_status = RSP_NOT_FOUND;
			end
		endcase
	end

	// Store: the clearing pass and the commit of a decision are the only writers.
	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			mem[clr_idx_q] <= '0;
		end else if (cmd.commit && wr_en_q) begin
			mem[wr_addr_q] <= '{state: wr_tomb_q ? SLOT_TOMB : SLOT_USED,
				key: key_q, value: wr_tomb_q ? '0 : wval_q};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= req_type;
			key_q      <= key_id;
			hash_q     <= key_hash;
			wval_q     <= write_value;
			rem_q      <= '0;
			idx_q      <= key_hash[IdxW-1:0];
		end else if (cmd.mod_step) begin
			rem_q <= rem_next;
			if (sts.mod_done) begin
				idx_q <= rem_next[IdxW-1:0];
			end
		end else if (cmd.check && !sts.probe_stop) begin
			idx_q <= idx_next;
		end
		if (cmd.check && !sts.probe_stop && cur_tomb && !tomb_seen_q) begin
			tomb_idx_q <= idx_q;
		end
		if (cmd.check && sts.probe_stop) begin
			res_status_q <= dec_status;
			res_value_q  <= dec_value;
			wr_addr_q    <= dec_addr;
			wr_tomb_q    <= dec_tomb;
		end
		if (cmd.commit) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_value_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q   <= '0;
			mod_cnt_q   <= '0;
			cnt_q       <= '0;
			tomb_seen_q <= 1'b0;
			used_q      <= '0;
			wr_en_q     <= 1'b0;
			inc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_step) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (cmd.load) begin
				mod_cnt_q <= ModCntW'(HashW - 1);
			end else if (cmd.mod_step) begin
				mod_cnt_q <= mod_cnt_q - 1'b1;
			end
			if (cmd.lookup) begin
				cnt_q       <= '0;
				tomb_seen_q <= 1'b0;
			end else if (cmd.check && !sts.probe_stop) begin
				cnt_q <= cnt_q + 1'b1;
				if (cur_tomb) begin
					tomb_seen_q <= 1'b1;
				end
			end
			if (cmd.check && sts.probe_stop) begin
				wr_en_q <= dec_wr;
				inc_q   <= dec_inc;
			end
			if (cmd.commit && inc_q) begin
				used_q <= used_q + 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`OAHT_NEVER(a_load_limit, used_q > CntW'(LoadLimit), "occupancy above the load limit")
	`OAHT_ASSERT(a_inc_is_insert, cmd.commit && inc_q |-> res_status_q == RSP_INSERTED, "occupancy raised without an insert")
	`OAHT_ASSERT(a_commit_free, cmd.commit |-> !out_valid_q || rsp_ready, "result register overwritten")

endmodule

// ===== hw/rtl/open_addressing_hash_table.sv =====
// An accepted request is loaded, the lookup reads its start slot, and each check step
// tests one slot while the linear probe reads the next (one slot read per cycle); once
// the response register is free, the commit moves the result into it. A request is taken
// only after the previous one commits; a slot count that is not a power of two adds a
// bit-serial start slot reduction. Reset: arst_n clears all control state, then a clearing
// pass writes every slot empty, one slot per cycle, with request ready held low until it ends.
// ----------------------------------------------------------------------------
// Open addressing hash table
// Linear probing key/value table with tombstones and a three quarter load limit.
// ----------------------------------------------------------------------------
module open_addressing_hash_table import oaht_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	oaht_req_if.sink   req,
	oaht_rsp_if.source rsp
);

	// The controller owns the sequence: clearing pass, request load, optional
	// start slot reduction, the lookup, the probe walk and the commit.
	// The datapath owns the slot store, the probe registers and the response
	// register. They talk only through the command and status structs below.
	oaht_cmd_t cmd;
	oaht_sts_t sts;

	// A request is taken only when no earlier request is still being worked on.
	// The response register parts the two sides, so a new request may be taken
	// while the previous response still waits on the sink.
	oaht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Each probe step reads one slot from the store; the read data is checked
	// in the following cycle while the next slot is already being read. A set
	// remembers the first tombstone it passes and reuses it if the key is not
	// found, and only a set that takes a truly empty slot raises the occupancy count.
	oaht_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req.req_type),
		.key_id      (req.key_id),
		.key_hash    (req.key_hash),
		.write_value (req.write_value),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.status      (rsp.status),
		.read_value  (rsp.read_value)
	);

endmodule
